[src/packbits_style_run_length_decoder_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the run-length decoder unit
// ---------------------------------------------------------------------------
`ifndef PACKBITS_STYLE_RUN_LENGTH_DECODER_UNIT_ASSERT_SVH
`define PACKBITS_STYLE_RUN_LENGTH_DECODER_UNIT_ASSERT_SVH

// Expression must hold at every clock edge out of reset.
`define PBRLD_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("pbrld assertion failed");

// When pre holds, post must hold at the next edge.
`define PBRLD_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pbrld assertion failed");

`endif

[src/pbrld_pkg.sv]
// ---------------------------------------------------------------------------
// pbrld_pkg
// Types and constants shared by the run-length decoder modules.
// ---------------------------------------------------------------------------
package pbrld_pkg;

    localparam logic [7:0] HEADER_LIMIT = 8'd127;
    localparam int         QUEUE_DEPTH  = 2;
    localparam int         QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int         QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       packet_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  data0;
        logic [7:0]  data1;
        logic [7:0]  data2;
        logic [7:0]  data3;
        logic [2:0]  byte_count;
        logic        last_of_item;
        logic        packet_done;
        logic [15:0] total_length;
        logic        truncated;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  value;
        logic [6:0]  count;
        logic        last;
        logic [15:0] total;
        logic        truncated;
    } cmd_t;

endpackage

[src/pbrld_front.sv]
// ---------------------------------------------------------------------------
// pbrld_front
// Accepts compressed bytes, tracks the header/literal/repeat state and
// emits one expansion command per byte that produces output or ends the packet.
// ---------------------------------------------------------------------------
module pbrld_front #(
    parameter int LENGTH_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  pbrld_pkg::in_item_t item,
    input  logic               queue_full,
    output logic               push,
    output pbrld_pkg::cmd_t    cmd
);

    localparam int SUM_BITS = LENGTH_BITS + 1;

    typedef enum logic [1:0] {
        MODE_HEADER,
        MODE_LITERAL,
        MODE_REPEAT
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [7:0]             run_reg, run_next;
    logic [6:0]             rep_reg, rep_next;
    logic [LENGTH_BITS-1:0] total_reg, total_next;
    logic [SUM_BITS-1:0]    sum;
    logic [6:0]             add;
    logic                   emit;
    logic                   accept;

    assign item_ready = !queue_full;
    assign accept     = item_valid && !queue_full;

    always_comb
    begin
        mode_next = mode_reg;
        run_next  = run_reg;
        rep_next  = rep_reg;
        add       = 7'd0;
        emit      = 1'b0;
        unique case (mode_reg)
            MODE_LITERAL:
            begin
                emit     = 1'b1;
                add      = 7'd1;
                run_next = run_reg - 8'd1;
                if (run_next == 8'd0)
                begin
                    mode_next = MODE_HEADER;
                end
            end
            MODE_REPEAT:
            begin
                emit      = (rep_reg != 7'd0);
                add       = rep_reg;
                rep_next  = 7'd0;
                mode_next = MODE_HEADER;
            end
            default:
            begin
                if (item.in_byte > pbrld_pkg::HEADER_LIMIT)
                begin
                    run_next  = 8'(9'd256 - {1'b0, item.in_byte});
                    mode_next = MODE_LITERAL;
                end
                else
                begin
                    rep_next  = item.in_byte[6:0];
                    mode_next = MODE_REPEAT;
                end
            end
        endcase

        sum        = {1'b0, total_reg} + SUM_BITS'(add);
        total_next = sum[LENGTH_BITS] ? '1 : sum[LENGTH_BITS-1:0];

        cmd.value     = item.in_byte;
        cmd.count     = add;
        cmd.last      = item.packet_last;
        cmd.total     = item.packet_last ? 16'(total_next) : 16'd0;
        cmd.truncated = item.packet_last &&
                        (mode_next == MODE_LITERAL || mode_next == MODE_REPEAT);
    end

    assign push = accept && (emit || item.packet_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_HEADER;
            run_reg   <= 8'd0;
            rep_reg   <= 7'd0;
            total_reg <= '0;
        end
        else if (accept)
        begin
            if (item.packet_last)
            begin
                mode_reg  <= MODE_HEADER;
                run_reg   <= 8'd0;
                rep_reg   <= 7'd0;
                total_reg <= '0;
            end
            else
            begin
                mode_reg  <= mode_next;
                run_reg   <= run_next;
                rep_reg   <= rep_next;
                total_reg <= total_next;
            end
        end
    end

endmodule

[src/pbrld_queue.sv]
// ---------------------------------------------------------------------------
// pbrld_queue
// Short command queue between the front and the back.
// ---------------------------------------------------------------------------
module pbrld_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pbrld_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output pbrld_pkg::cmd_t head
);

    pbrld_pkg::cmd_t                       slots [pbrld_pkg::QUEUE_DEPTH];
    logic [pbrld_pkg::QPTR_BITS-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [pbrld_pkg::QCNT_BITS-1:0]       cnt_reg, cnt_next;

    assign full       = (cnt_reg == pbrld_pkg::QCNT_BITS'(pbrld_pkg::QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = slots[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + pbrld_pkg::QCNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - pbrld_pkg::QCNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[src/pbrld_back.sv]
// ---------------------------------------------------------------------------
// pbrld_back
// Expands queued commands into results of up to four bytes each and holds
// them in the output register.
// ---------------------------------------------------------------------------
module pbrld_back #(
    parameter int OUT_LANES = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  pbrld_pkg::cmd_t      head,
    output logic                 pop,
    output logic                 result_valid,
    input  logic                 result_ready,
    output pbrld_pkg::out_item_t result
);

    localparam int LANES = (OUT_LANES < 1) ? 1 : ((OUT_LANES > 4) ? 4 : OUT_LANES);
    localparam logic [6:0] LANE_COUNT = 7'(LANES);

    logic                 active_reg;
    logic [6:0]           left_reg;
    logic                 valid_reg;
    pbrld_pkg::out_item_t result_reg, result_next;
    logic [6:0]           left, cnt, rem;
    logic                 load, item_end;

    assign left     = active_reg ? left_reg : head.count;
    assign cnt      = (left > LANE_COUNT) ? LANE_COUNT : left;
    assign rem      = left - cnt;
    assign item_end = (rem == 7'd0);
    assign load     = head_valid && (!valid_reg || result_ready);
    assign pop      = load && item_end;

    always_comb
    begin
        result_next.data0        = (cnt > 7'd0) ? head.value : 8'd0;
        result_next.data1        = (cnt > 7'd1) ? head.value : 8'd0;
        result_next.data2        = (cnt > 7'd2) ? head.value : 8'd0;
        result_next.data3        = (cnt > 7'd3) ? head.value : 8'd0;
        result_next.byte_count   = cnt[2:0];
        result_next.last_of_item = item_end;
        result_next.packet_done  = item_end && head.last;
        result_next.total_length = (item_end && head.last) ? head.total : 16'd0;
        result_next.truncated    = item_end && head.last && head.truncated;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            left_reg   <= 7'd0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg  <= 1'b1;
                active_reg <= !item_end;
                left_reg   <= rem;
            end
            else if (result_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

[src/packbits_style_run_length_decoder_unit.sv]
// ---------------------------------------------------------------------------
// packbits_style_run_length_decoder_unit
// Run-length decoder: one compressed byte in per beat, packed bytes out.
// ---------------------------------------------------------------------------
// Input channel item_valid/item_ready/item carries one compressed byte and
// the packet end mark. Output channel result_valid/result_ready/result
// carries up to four decoded bytes plus item and packet end status.
// A literal byte yields one result; a repeat value with n copies yields
// ceil(n / lanes) results, one per cycle while the receiver takes them, as
// set by the back-end expansion counter. Header bytes yield no result unless
// they end the packet. A byte's command is queued first, and its results are
// then registered in the output register. The input takes one byte per cycle
// while the two-entry command queue has room; it fills when the receiver
// stalls or a repeat run is expanding, and item_ready then drops until the
// back end pops a command. Reset clears decode state, queue and result_valid.
// ---------------------------------------------------------------------------
module packbits_style_run_length_decoder_unit #(
    parameter int OUT_LANES   = 4,
    parameter int LENGTH_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  pbrld_pkg::in_item_t  item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output pbrld_pkg::out_item_t result
);

    logic            push, full, pop, head_valid;
    pbrld_pkg::cmd_t push_cmd, head;

    pbrld_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .queue_full (full),
        .push       (push),
        .cmd        (push_cmd)
    );

    pbrld_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    pbrld_back #(
        .OUT_LANES (OUT_LANES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

[src/pbrld_checker.sv]
// ---------------------------------------------------------------------------
// pbrld_checker
// Port-level checks on the run-length decoder result channel.
// ---------------------------------------------------------------------------
`include "packbits_style_run_length_decoder_unit_assert.svh"

module pbrld_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 result_valid,
    input logic                 result_ready,
    input pbrld_pkg::out_item_t result
);

    `PBRLD_ASSERT_NEXT(a_hold, clk, rst_n, result_valid && !result_ready,
                       result_valid && $stable(result))
    `PBRLD_ASSERT(a_count, clk, rst_n, !result_valid || result.byte_count <= 3'd4)
    `PBRLD_ASSERT(a_done_last, clk, rst_n,
                  !result_valid || !result.packet_done || result.last_of_item)
    `PBRLD_ASSERT(a_status_zero, clk, rst_n,
                  !result_valid || result.packet_done ||
                  (result.total_length == 16'd0 && !result.truncated))
    `PBRLD_ASSERT(a_empty_end, clk, rst_n,
                  !result_valid || result.byte_count != 3'd0 || result.packet_done)

endmodule

bind packbits_style_run_length_decoder_unit pbrld_checker u_pbrld_checker (.*);

[tb/tb_packbits_style_run_length_decoder_unit.sv]
// ---------------------------------------------------------------------------
// tb_packbits_style_run_length_decoder_unit
// Self-checking testbench for the run-length decoder unit. Every compressed
// byte accepted on the input is decoded by a local model. The model queues the
// output beats it expects, and each beat that leaves the block is checked
// field by field against the oldest one. Directed runs cover the count and
// packet-end corners. Random packets follow, mostly well formed with some cut
// short and some noise. A long stall on the receive side fills the block.
// ---------------------------------------------------------------------------
module tb_packbits_style_run_length_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OUT_LANES    = 4;
    localparam int LENGTH_BITS  = 16;
    localparam int LEN_MAX      = (1 << LENGTH_BITS) - 1;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 70;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic [1:0] {
        EXPECT_HEADER,
        IN_LITERAL,
        EXPECT_VALUE
    } dec_mode_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_ready;
    pbrld_pkg::in_item_t  item         = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    pbrld_pkg::out_item_t result;

    packbits_style_run_length_decoder_unit #(
        .OUT_LANES   (OUT_LANES),
        .LENGTH_BITS (LENGTH_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #6 clk = ~clk;

    pbrld_pkg::out_item_t decoded_q[$];
    logic [7:0]           pkt_bytes[$];

    dec_mode_t   dec_mode   = EXPECT_HEADER;
    logic [7:0]  lit_left   = '0;
    logic [6:0]  rep_copies = '0;
    logic [15:0] pkt_total  = '0;

    int err_count     = 0;
    int bytes_sent    = 0;
    int packets_sent  = 0;
    int beats_checked = 0;

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int hold_len   = 0;
    int hold_seq   = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] add_sat(logic [15:0] t, int n);
        int sum;
        sum = int'(t) + n;
        return (sum > LEN_MAX) ? 16'(LEN_MAX) : 16'(sum);
    endfunction

    function automatic string fmt_beat(pbrld_pkg::out_item_t b);
        return $sformatf("data=%02h %02h %02h %02h cnt=%0d last=%0b done=%0b len=%0d trunc=%0b",
                         b.data0, b.data1, b.data2, b.data3, b.byte_count,
                         b.last_of_item, b.packet_done, b.total_length, b.truncated);
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("ERROR: %s", msg);
    endtask

    // Decode one accepted byte and queue the beats it produces.
    task automatic decode_byte(input pbrld_pkg::in_item_t it);
        pbrld_pkg::out_item_t beat;
        pbrld_pkg::out_item_t batch[$];
        int                   left;
        int                   c;
        case (dec_mode)
            IN_LITERAL:
            begin
                beat            = '0;
                beat.data0      = it.in_byte;
                beat.byte_count = 3'd1;
                batch.push_back(beat);
                pkt_total = add_sat(pkt_total, 1);
                lit_left  = lit_left - 8'd1;
                if (lit_left == 8'd0)
                    dec_mode = EXPECT_HEADER;
            end
            EXPECT_VALUE:
            begin
                left = int'(rep_copies);
                while (left > 0)
                begin
                    c          = (left > OUT_LANES) ? OUT_LANES : left;
                    beat       = '0;
                    beat.data0 = it.in_byte;
                    if (c > 1)
                        beat.data1 = it.in_byte;
                    if (c > 2)
                        beat.data2 = it.in_byte;
                    if (c > 3)
                        beat.data3 = it.in_byte;
                    beat.byte_count = 3'(c);
                    batch.push_back(beat);
                    left -= c;
                end
                pkt_total  = add_sat(pkt_total, int'(rep_copies));
                rep_copies = '0;
                dec_mode   = EXPECT_HEADER;
            end
            default:
            begin
                if (it.in_byte > pbrld_pkg::HEADER_LIMIT)
                begin
                    lit_left = 8'(256 - int'(it.in_byte));
                    dec_mode = IN_LITERAL;
                end
                else
                begin
                    rep_copies = it.in_byte[6:0];
                    dec_mode   = EXPECT_VALUE;
                end
            end
        endcase
        if (it.packet_last && batch.size() == 0)
        begin
            beat = '0;
            batch.push_back(beat);
        end
        if (batch.size() > 0)
        begin
            beat              = batch.pop_back();
            beat.last_of_item = 1'b1;
            if (it.packet_last)
            begin
                beat.packet_done  = 1'b1;
                beat.total_length = pkt_total;
                beat.truncated    = (dec_mode != EXPECT_HEADER);
                dec_mode          = EXPECT_HEADER;
                lit_left          = '0;
                rep_copies        = '0;
                pkt_total         = '0;
            end
            batch.push_back(beat);
        end
        foreach (batch[i])
            decoded_q.push_back(batch[i]);
    endtask

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_item(input logic [7:0] b, input logic last);
        int                  gap;
        pbrld_pkg::in_item_t it;
        gap            = tx_idle_en ? pick_gap() : 0;
        it.in_byte     = b;
        it.packet_last = last;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        decode_byte(it);
        bytes_sent++;
        if (last)
            packets_sent++;
        @(negedge clk);
    endtask

    task automatic send_packet(input int last_at);
        for (int i = 0; i <= last_at; i++)
            send_item(pkt_bytes[i], i == last_at);
    endtask

    task automatic build_packet();
        int runs;
        int len;
        int r;
        pkt_bytes.delete();
        runs = $urandom_range(1, 6);
        for (int k = 0; k < runs; k++)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 1) == 0)
            begin
                if (r < 85)
                    len = $urandom_range(1, 6);
                else if (r < 95)
                    len = $urandom_range(7, 40);
                else
                    len = $urandom_range(41, 128);
                pkt_bytes.push_back(8'(256 - len));
                for (int j = 0; j < len; j++)
                    pkt_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                len = (r < 85) ? $urandom_range(0, 12) : $urandom_range(13, 127);
                pkt_bytes.push_back(8'(len));
                pkt_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic wait_drain();
        item_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic test_repeat_counts();
        send_item(8'h00, 1'b0);
        send_item(8'h55, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h04, 1'b0);
        send_item(8'h11, 1'b0);
        send_item(8'h05, 1'b0);
        send_item(8'h22, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(8'hA5, 1'b1);
        wait_drain();
    endtask

    task automatic test_literal_runs();
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFC, 1'b0);
        send_item(8'hDE, 1'b0);
        send_item(8'hAD, 1'b0);
        send_item(8'hBE, 1'b0);
        send_item(8'hEF, 1'b1);
        wait_drain();
    endtask

    task automatic test_packet_ends();
        // header alone ends the packet
        send_item(8'h03, 1'b1);
        send_item(8'hFE, 1'b1);
        // zero-copy value ends the packet cleanly
        send_item(8'h00, 1'b0);
        send_item(8'h77, 1'b1);
        // cut inside a literal run
        send_item(8'hFC, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'h02, 1'b1);
        // cut while a repeat value is pending
        send_item(8'h02, 1'b0);
        send_item(8'h44, 1'b0);
        send_item(8'h09, 1'b1);
        wait_drain();
    endtask

    task automatic test_max_literal();
        pkt_bytes.delete();
        pkt_bytes.push_back(8'h80);
        for (int j = 0; j < 128; j++)
            pkt_bytes.push_back(8'($urandom_range(0, 255)));
        send_packet(pkt_bytes.size() - 1);
        wait_drain();
    endtask

    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        @(posedge clk);
        hold_len = 80;
        hold_seq++;
        @(negedge clk);
        for (int k = 0; k < 6; k++)
        begin
            send_item(8'h10, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b0);
        end
        send_item(8'hF8, 1'b0);
        for (int j = 0; j < 8; j++)
            send_item(8'($urandom_range(0, 255)), j == 7);
        tx_idle_en = 1'b1;
        wait_drain();
    endtask

    task automatic test_random_packets();
        int start;
        int r;
        int n;
        int cut;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                tx_idle_en = ~tx_idle_en;
            if ($urandom_range(0, 9) == 0)
                rx_idle_en = ~rx_idle_en;
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_item(8'($urandom_range(0, 255)),
                              (i == n - 1) || ($urandom_range(0, 3) == 0));
            end
            else
            begin
                build_packet();
                if (r < 30)
                    cut = $urandom_range(0, pkt_bytes.size() - 2);
                else
                    cut = pkt_bytes.size() - 1;
                send_packet(cut);
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        wait_drain();
    endtask

    // Receive side: random stalls plus requested long hold-offs.
    initial
    begin
        int stall_left;
        int hold_left;
        int hold_seen;
        stall_left = 0;
        hold_left  = 0;
        hold_seen  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                if (rx_idle_en)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        pbrld_pkg::out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            beats_checked++;
            if (decoded_q.size() == 0)
                flag_error({"unexpected beat: ", fmt_beat(result)});
            else
            begin
                want = decoded_q.pop_front();
                if (result.data0 !== want.data0 || result.data1 !== want.data1 ||
                    result.data2 !== want.data2 || result.data3 !== want.data3 ||
                    result.byte_count !== want.byte_count ||
                    result.last_of_item !== want.last_of_item ||
                    result.packet_done !== want.packet_done ||
                    result.total_length !== want.total_length ||
                    result.truncated !== want.truncated)
                    flag_error($sformatf("mismatch: expected %s, got %s",
                                         fmt_beat(want), fmt_beat(result)));
            end
        end
    end

    initial
    begin
        #30_000_000;
        $display("packbits_style_run_length_decoder_unit regression: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_repeat_counts();
        test_literal_runs();
        test_packet_ends();
        test_max_literal();
        test_backpressure();
        test_random_packets();

        $display("decoded %0d compressed bytes in %0d packets, %0d output beats checked",
                 bytes_sent, packets_sent, beats_checked);
        $display("runs: zero/one/max repeats, 1..128 byte literals, cut packets, noise, %s",
                 "long stall");
        if (err_count == 0 && decoded_q.size() == 0)
            $display("packbits_style_run_length_decoder_unit regression: pass");
        else
            $display("packbits_style_run_length_decoder_unit regression: fail");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/pbrld_pkg.sv
src/pbrld_front.sv
src/pbrld_queue.sv
src/pbrld_back.sv
src/packbits_style_run_length_decoder_unit.sv
src/pbrld_checker.sv
tb/tb_packbits_style_run_length_decoder_unit.sv
